// ----- design/jsu_pkg.sv -----
// Package for the JSON string unescaper: mode codes, character codes, result types, helpers.
package jsu_pkg;

    localparam int MAX_RES = 6;

    typedef enum logic [2:0] {
        M_NORMAL  = 3'd0,
        M_ESC     = 3'd1,
        M_HEX     = 3'd2,
        M_HELD    = 3'd3,
        M_HELD_BS = 3'd4,
        M_LOW_HEX = 3'd5,
        M_DONE    = 3'd6
    } t_mode;

    localparam logic [2:0] HEX_LAST = 3'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [20:0] CP_MAX1   = 21'h7F;
    localparam logic [20:0] CP_MAX2   = 21'h7FF;
    localparam logic [20:0] CP_MAX3   = 21'hFFFF;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } t_enc;

    typedef struct packed {
        t_mode mode;
        logic  clr_hex;
        logic  is_end;
        t_enc  res;
    } t_act;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic       last;
    } t_res;

    function automatic t_hex f_hex(input logic [7:0] b);
        t_hex h;
        h = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            h.ok  = 1'b1;
            h.val = b[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic t_enc f_encode(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp <= CP_MAX1) begin
            e.cnt      = 3'd1;
            e.bytes[0] = cp[7:0];
        end else if (cp <= CP_MAX2) begin
            e.cnt      = 3'd2;
            e.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            e.bytes[1] = CONT | {2'b00, cp[5:0]};
        end else if (cp <= CP_MAX3) begin
            e.cnt      = 3'd3;
            e.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT | {2'b00, cp[11:6]};
            e.bytes[2] = CONT | {2'b00, cp[5:0]};
        end else begin
            e.cnt      = 3'd4;
            e.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT | {2'b00, cp[17:12]};
            e.bytes[2] = CONT | {2'b00, cp[11:6]};
            e.bytes[3] = CONT | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

    function automatic t_act f_normal(input logic [7:0] b);
        t_act a;
        a      = '0;
        a.mode = M_NORMAL;
        if (b == CH_NUL || b == CH_QUOTE) begin
            a.is_end = 1'b1;
            a.mode   = M_DONE;
        end else if (b == CH_BSLASH) begin
            a.mode = M_ESC;
        end else begin
            a.res.cnt      = 3'd1;
            a.res.bytes[0] = b;
        end
        return a;
    endfunction

    function automatic t_act f_escaped(input logic [7:0] b);
        t_act a;
        a              = '0;
        a.mode         = M_NORMAL;
        a.res.cnt      = 3'd1;
        a.res.bytes[0] = b;
        case (b)
            CH_NUL: begin
                a.is_end  = 1'b1;
                a.res.cnt = 3'd0;
                a.mode    = M_DONE;
            end
            CH_N: a.res.bytes[0] = CH_LF;
            CH_R: a.res.bytes[0] = CH_CR;
            CH_T: a.res.bytes[0] = CH_TAB;
            CH_U: begin
                a.res.cnt = 3'd0;
                a.mode    = M_HEX;
                a.clr_hex = 1'b1;
            end
            default: ;
        endcase
        return a;
    endfunction

endpackage

// ----- design/jsu_in_if.sv -----
// Input stream interface: one escaped string byte per beat.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_req;

    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

// ----- design/jsu_out_if.sv -----
// Output stream interface: one UTF-8 byte or end marker per beat.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output string_done,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                    input last, output ready);
endinterface

// ----- design/json_string_unescape_utf8_unit.sv -----
// JSON string body unescaper producing UTF-8 bytes, with input and result registers.
//
// One escaped byte is taken per beat; its decode (escapes, \uXXXX, surrogate
// pairing, end of string) runs combinationally between the input register and a
// six-entry result buffer, which then drains one result per cycle while the
// output is ready. An input byte that yields k results (k from 0 to 6) holds the
// processing stage until its results are taken, so the output port sets the
// rate: one beat per cycle on input for plain text, one result beat per cycle on
// output. A byte passes the input register and then the result buffer before its
// first result is offered. After a quote or zero byte ends the string, one end
// marker is given and later bytes give nothing until start_req.
module json_string_unescape_utf8_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    logic            r_in_v;
    logic [7:0]      r_in_byte;
    logic            r_in_start;

    jsu_pkg::t_mode  r_mode;
    logic [2:0]      r_digits;
    logic [15:0]     r_acc;
    logic [15:0]     r_held;

    jsu_pkg::t_res   r_obuf [0:jsu_pkg::MAX_RES-1];
    logic [2:0]      r_cnt;
    logic [2:0]      r_idx;

    jsu_pkg::t_mode  eff_mode;
    logic [2:0]      eff_digits;
    logic [15:0]     eff_acc;
    logic [15:0]     eff_held;
    jsu_pkg::t_hex   hx;
    logic [15:0]     acc_sh;
    logic            code_done;
    logic            a_en;
    jsu_pkg::t_act   act;

    jsu_pkg::t_mode  n_mode;
    logic [2:0]      n_digits;
    logic [15:0]     n_acc;
    logic [15:0]     n_held;
    jsu_pkg::t_res   n_obuf [0:jsu_pkg::MAX_RES-1];
    logic [2:0]      n_cnt;

    jsu_pkg::t_enc   a_enc;
    logic [2:0]      a_n;
    logic [2:0]      b_n;

    logic            o_valid;
    logic            o_fire;
    logic            last_slot;
    logic            free;
    logic            proc;
    logic            in_fire;

    // decode and next state
    always_comb begin
        eff_mode   = r_in_start ? jsu_pkg::M_NORMAL : r_mode;
        eff_digits = r_in_start ? 3'd0 : r_digits;
        eff_acc    = r_in_start ? 16'd0 : r_acc;
        eff_held   = r_in_start ? 16'd0 : r_held;
        hx         = jsu_pkg::f_hex(r_in_byte);
        acc_sh     = {eff_acc[11:0], hx.val};
        act        = '0;
        act.mode   = eff_mode;
        a_en       = 1'b0;
        code_done  = 1'b0;
        n_digits   = eff_digits;
        n_acc      = eff_acc;
        n_held     = eff_held;
        unique case (eff_mode)
            jsu_pkg::M_ESC: act = jsu_pkg::f_escaped(r_in_byte);
            jsu_pkg::M_HEX: begin
                if (!hx.ok) begin
                    act = jsu_pkg::f_normal(r_in_byte);
                end else begin
                    n_acc = acc_sh;
                    if (eff_digits >= jsu_pkg::HEX_LAST) begin
                        n_digits  = 3'd0;
                        code_done = 1'b1;
                    end else begin
                        n_digits = eff_digits + 3'd1;
                    end
                end
            end
            jsu_pkg::M_HELD: begin
                if (r_in_byte == jsu_pkg::CH_BSLASH) begin
                    act.mode = jsu_pkg::M_HELD_BS;
                end else begin
                    a_en = 1'b1;
                    act  = jsu_pkg::f_normal(r_in_byte);
                end
            end
            jsu_pkg::M_HELD_BS: begin
                if (r_in_byte == jsu_pkg::CH_U) begin
                    act.mode    = jsu_pkg::M_LOW_HEX;
                    act.clr_hex = 1'b1;
                end else begin
                    a_en = 1'b1;
                    act  = jsu_pkg::f_escaped(r_in_byte);
                end
            end
            jsu_pkg::M_LOW_HEX: begin
                if (!hx.ok) begin
                    a_en = 1'b1;
                    act  = jsu_pkg::f_normal(r_in_byte);
                end else begin
                    n_acc = acc_sh;
                    if (eff_digits >= jsu_pkg::HEX_LAST) begin
                        n_digits = 3'd0;
                        if (acc_sh >= jsu_pkg::LO_SUR_MIN && acc_sh <= jsu_pkg::LO_SUR_MAX) begin
                            act.res  = jsu_pkg::f_encode(jsu_pkg::SUPP_BASE +
                                           {1'b0, eff_held[9:0], acc_sh[9:0]});
                            act.mode = jsu_pkg::M_NORMAL;
                        end else begin
                            a_en      = 1'b1;
                            code_done = 1'b1;
                        end
                    end else begin
                        n_digits = eff_digits + 3'd1;
                    end
                end
            end
            jsu_pkg::M_DONE: ;
            default: act = jsu_pkg::f_normal(r_in_byte);
        endcase
        if (code_done) begin
            if (acc_sh >= jsu_pkg::HI_SUR_MIN && acc_sh <= jsu_pkg::HI_SUR_MAX) begin
                n_held   = acc_sh;
                act.mode = jsu_pkg::M_HELD;
            end else begin
                act.res  = jsu_pkg::f_encode({5'd0, acc_sh});
                act.mode = jsu_pkg::M_NORMAL;
            end
        end
        if (act.clr_hex) begin
            n_digits = 3'd0;
            n_acc    = 16'd0;
        end
        n_mode = act.mode;
    end

    // result list: held surrogate bytes first, then this byte's own results
    always_comb begin
        a_enc = jsu_pkg::f_encode({5'd0, eff_held});
        a_n   = a_en ? 3'd3 : 3'd0;
        b_n   = act.is_end ? 3'd1 : act.res.cnt;
        n_cnt = a_n + b_n;
        for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
            n_obuf[i] = '0;
            if (3'(i) < a_n) begin
                n_obuf[i].out_byte   = a_enc.bytes[2'(i)];
                n_obuf[i].byte_valid = 1'b1;
            end else if ((3'(i) - a_n) < b_n) begin
                if (act.is_end) begin
                    n_obuf[i].string_done = 1'b1;
                end else begin
                    n_obuf[i].out_byte   = act.res.bytes[2'(3'(i) - a_n)];
                    n_obuf[i].byte_valid = 1'b1;
                end
            end
            n_obuf[i].last = (3'(i) == n_cnt - 3'd1);
        end
    end

    assign o_valid   = (r_idx != r_cnt);
    assign o_fire    = o_valid && o_out.ready;
    assign last_slot = (r_idx == r_cnt - 3'd1);
    assign free      = !o_valid || (o_fire && last_slot);
    assign proc      = r_in_v && free;
    assign in_fire   = i_in.valid && i_in.ready;

    assign i_in.ready        = !r_in_v || proc;
    assign o_out.valid       = o_valid;
    assign o_out.out_byte    = r_obuf[r_idx].out_byte;
    assign o_out.byte_valid  = r_obuf[r_idx].byte_valid;
    assign o_out.string_done = r_obuf[r_idx].string_done;
    assign o_out.last        = r_obuf[r_idx].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_mode   <= jsu_pkg::M_NORMAL;
            r_digits <= 3'd0;
            r_acc    <= 16'd0;
            r_held   <= 16'd0;
            r_cnt    <= 3'd0;
            r_idx    <= 3'd0;
        end else begin
            if (in_fire) begin
                r_in_v <= 1'b1;
            end else if (proc) begin
                r_in_v <= 1'b0;
            end
            if (proc) begin
                r_mode   <= n_mode;
                r_digits <= n_digits;
                r_acc    <= n_acc;
                r_held   <= n_held;
                r_cnt    <= n_cnt;
                r_idx    <= 3'd0;
            end else if (o_fire) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_in.in_byte;
            r_in_start <= i_in.start_req;
        end
        if (proc) begin
            r_obuf <= n_obuf;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_cnt && r_cnt <= 3'(jsu_pkg::MAX_RES))
        else $error("result buffer count out of range");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.string_done |-> o_out.last && !o_out.byte_valid)
        else $error("end marker not final or carries data");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire && !o_out.last |=> o_valid)
        else $error("result run broken before last beat");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_mode == jsu_pkg::M_DONE && !r_in_start |-> n_cnt == 3'd0)
        else $error("results produced after end of string");

endmodule
